[src/tdsc_pkg.sv]
`default_nettype none

package tdsc_pkg;

    // fixed point layout of the filter state
    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FILT_W     = SAMPLE_W + FRAC_BITS;
    localparam int SQ_W       = 2 * FILT_W;
    localparam int WEIGHT_W   = 9;
    localparam int WEIGHT_ONE = 256;
    localparam int WEIGHT_SH  = 8;
    localparam int THR_W      = 15;
    localparam int TAN2_W     = 16;
    localparam int PROD_W     = TAN2_W + FILT_W;
    localparam int CMP_W      = TAN2_W + SQ_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN2_HIGH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN2_MID         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN2_LOW         = 3'd4;

    localparam logic [WEIGHT_W-1:0] RST_SMOOTHING_WEIGHT = 9'd128;
    localparam logic [THR_W-1:0]    RST_TILT_LIMIT       = 15'd1800;
    localparam logic [TAN2_W-1:0]   RST_TAN2_HIGH        = 16'd1932;
    localparam logic [TAN2_W-1:0]   RST_TAN2_MID         = 16'd256;
    localparam logic [TAN2_W-1:0]   RST_TAN2_LOW         = 16'd56;

    // direction codes
    localparam logic [2:0] DIR_NEUTRAL  = 3'd0;
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_BACKWARD = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_RIGHT    = 3'd4;

    // speed levels
    localparam logic [2:0] SPEED_NONE = 3'd0;
    localparam logic [2:0] SPEED_1    = 3'd1;
    localparam logic [2:0] SPEED_2    = 3'd2;
    localparam logic [2:0] SPEED_3    = 3'd3;
    localparam logic [2:0] SPEED_4    = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } tdsc_in_t;

    typedef struct packed {
        logic [2:0] direction;
        logic [2:0] speed;
    } tdsc_out_t;

    // step enables from the sequencer
    typedef struct packed {
        logic filt_en;
        logic sq_en;
        logic sel_en;
        logic mul_en;
    } tdsc_ctrl_t;

endpackage

`default_nettype wire

[src/tilt_direction_speed_classifier.sv]
`default_nettype none
// steps from input transfer to result valid: filter, square, select, multiply,
//   compare (held while the output is blocked), run by the step sequencer that drives the three axis lanes
// one item at a time; input takes a new item while a result waits
// reset: filter state cleared to zero, registers to defaults, output empty

module tilt_direction_speed_classifier (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire tdsc_pkg::tdsc_in_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output tdsc_pkg::tdsc_out_t                     out_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tdsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_SQR,
        ST_SEL,
        ST_MUL,
        ST_CMP
    } state_t;

    state_t                              state_reg;
    logic                                out_valid_reg;
    tdsc_pkg::tdsc_out_t                 out_data_reg;
    tdsc_pkg::tdsc_in_t                  in_data_reg;
    tdsc_pkg::tdsc_ctrl_t                ctrl;
    tdsc_pkg::tdsc_out_t                 result;

    logic [tdsc_pkg::WEIGHT_W-1:0]       weight_reg;
    logic [tdsc_pkg::THR_W-1:0]          threshold_reg;
    logic [tdsc_pkg::TAN2_W-1:0]         tan2_high_reg;
    logic [tdsc_pkg::TAN2_W-1:0]         tan2_mid_reg;
    logic [tdsc_pkg::TAN2_W-1:0]         tan2_low_reg;
    logic [tdsc_pkg::WEIGHT_W-1:0]       weight_eff;

    logic signed [tdsc_pkg::FILT_W-1:0]  filt_x;
    logic signed [tdsc_pkg::FILT_W-1:0]  filt_y;
    logic signed [tdsc_pkg::FILT_W-1:0]  filt_z;
    logic [tdsc_pkg::SQ_W-1:0]           sq_x;
    logic [tdsc_pkg::SQ_W-1:0]           sq_y;
    logic [tdsc_pkg::SQ_W-1:0]           sq_z;

    logic                                in_xfer;
    logic                                out_xfer;
    logic                                out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // weights above one saturate to one
    assign weight_eff = (weight_reg > tdsc_pkg::WEIGHT_W'(tdsc_pkg::WEIGHT_ONE))
                        ? tdsc_pkg::WEIGHT_W'(tdsc_pkg::WEIGHT_ONE) : weight_reg;

    // step enables
    always_comb
    begin
        ctrl.filt_en = (state_reg == ST_FILT);
        ctrl.sq_en   = (state_reg == ST_SQR);
        ctrl.sel_en  = (state_reg == ST_SEL);
        ctrl.mul_en  = (state_reg == ST_MUL);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= tdsc_pkg::RST_SMOOTHING_WEIGHT;
            threshold_reg <= tdsc_pkg::RST_TILT_LIMIT;
            tan2_high_reg <= tdsc_pkg::RST_TAN2_HIGH;
            tan2_mid_reg  <= tdsc_pkg::RST_TAN2_MID;
            tan2_low_reg  <= tdsc_pkg::RST_TAN2_LOW;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tdsc_pkg::CFG_SMOOTHING_WEIGHT:
                    weight_reg <= cfg_wdata[tdsc_pkg::WEIGHT_W-1:0];
                tdsc_pkg::CFG_TILT_LIMIT:
                    threshold_reg <= cfg_wdata[tdsc_pkg::THR_W-1:0];
                tdsc_pkg::CFG_TAN2_HIGH:
                    tan2_high_reg <= cfg_wdata[tdsc_pkg::TAN2_W-1:0];
                tdsc_pkg::CFG_TAN2_MID:
                    tan2_mid_reg <= cfg_wdata[tdsc_pkg::TAN2_W-1:0];
                tdsc_pkg::CFG_TAN2_LOW:
                    tan2_low_reg <= cfg_wdata[tdsc_pkg::TAN2_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // input holding register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= in_data;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_xfer)
                    begin
                        state_reg <= ST_FILT;
                    end
                ST_FILT:
                    state_reg <= ST_SQR;
                ST_SQR:
                    state_reg <= ST_SEL;
                ST_SEL:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_CMP;
                ST_CMP:
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase

            if (state_reg == ST_CMP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP && out_free)
        begin
            out_data_reg <= result;
        end
    end

    // one lane per axis
    tdsc_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .weight (weight_eff),
        .sample (in_data_reg.accel_x),
        .filt   (filt_x),
        .sq     (sq_x)
    );

    tdsc_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .weight (weight_eff),
        .sample (in_data_reg.accel_y),
        .filt   (filt_y),
        .sq     (sq_y)
    );

    tdsc_lane u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .weight (weight_eff),
        .sample (in_data_reg.accel_z),
        .filt   (filt_z),
        .sq     (sq_z)
    );

    // direction and speed from the lane results
    tdsc_merge u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .filt_x     (filt_x),
        .filt_y     (filt_y),
        .sq_x       (sq_x),
        .sq_y       (sq_y),
        .sq_z       (sq_z),
        .tilt_limit (threshold_reg),
        .tan2_high  (tan2_high_reg),
        .tan2_mid   (tan2_mid_reg),
        .tan2_low   (tan2_low_reg),
        .result     (result)
    );

    // a result appears only right after the compare step
    a_out_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CMP))
        else $error("result loaded outside compare step");

    // compare step waits while the output register is blocked
    a_cmp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && out_valid_reg && out_stall) |=> (state_reg == ST_CMP))
        else $error("compare step left while output blocked");

    // speed is zero exactly when neutral
    a_speed_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.direction == tdsc_pkg::DIR_NEUTRAL)
                           == (out_data_reg.speed == tdsc_pkg::SPEED_NONE)))
        else $error("speed and direction disagree on neutral");

    // no new item while one is in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input open during processing");

    // z filter state moves only on the filter step
    a_filt_z_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FILT) |=> $stable(filt_z))
        else $error("z filter changed outside filter step");

endmodule

`default_nettype wire

[src/tdsc_lane.sv]
`default_nettype none

module tdsc_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tdsc_pkg::tdsc_ctrl_t                ctrl,
    input  wire logic [tdsc_pkg::WEIGHT_W-1:0]       weight,
    input  wire logic signed [tdsc_pkg::SAMPLE_W-1:0] sample,
    output logic signed [tdsc_pkg::FILT_W-1:0]       filt,
    output logic [tdsc_pkg::SQ_W-1:0]                sq
);

    localparam int PA_W  = tdsc_pkg::WEIGHT_W + 1 + tdsc_pkg::FILT_W;
    localparam int SUM_W = PA_W + 1;

    logic signed [tdsc_pkg::FILT_W-1:0]     filt_reg;
    logic signed [tdsc_pkg::FILT_W-1:0]     filt_next;
    logic [tdsc_pkg::SQ_W-1:0]              sq_reg;
    logic [tdsc_pkg::SQ_W-1:0]              sq_next;
    logic signed [tdsc_pkg::WEIGHT_W:0]     w_new;
    logic signed [tdsc_pkg::WEIGHT_W:0]     w_old;
    logic signed [tdsc_pkg::FILT_W-1:0]     xs;
    logic signed [PA_W-1:0]                 prod_new;
    logic signed [PA_W-1:0]                 prod_old;
    logic signed [SUM_W-1:0]                acc;
    logic [tdsc_pkg::FILT_W-1:0]            mag;

    // exponential filter, floor of acc / 256 by arithmetic shift
    always_comb
    begin
        w_new     = $signed({1'b0, weight});
        w_old     = $signed((tdsc_pkg::WEIGHT_W + 1)'(tdsc_pkg::WEIGHT_ONE))
                    - w_new;
        xs        = $signed({sample, {tdsc_pkg::FRAC_BITS{1'b0}}});
        prod_new  = PA_W'(w_new) * PA_W'(xs);
        prod_old  = PA_W'(w_old) * PA_W'(filt_reg);
        acc       = SUM_W'(prod_new) + SUM_W'(prod_old);
        filt_next = acc[tdsc_pkg::FILT_W + tdsc_pkg::WEIGHT_SH - 1 : tdsc_pkg::WEIGHT_SH];
    end

    // magnitude squared of the filtered value
    always_comb
    begin
        mag     = filt_reg[tdsc_pkg::FILT_W-1] ? $unsigned(-filt_reg) : $unsigned(filt_reg);
        sq_next = tdsc_pkg::SQ_W'(mag) * tdsc_pkg::SQ_W'(mag);
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (ctrl.filt_en)
        begin
            filt_reg <= filt_next;
        end
    end

    // square register
    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign filt = filt_reg;
    assign sq   = sq_reg;

endmodule

`default_nettype wire

[src/tdsc_merge.sv]
`default_nettype none

module tdsc_merge (
    input  wire logic                                clk,
    input  wire tdsc_pkg::tdsc_ctrl_t                ctrl,
    input  wire logic signed [tdsc_pkg::FILT_W-1:0]  filt_x,
    input  wire logic signed [tdsc_pkg::FILT_W-1:0]  filt_y,
    input  wire logic [tdsc_pkg::SQ_W-1:0]           sq_x,
    input  wire logic [tdsc_pkg::SQ_W-1:0]           sq_y,
    input  wire logic [tdsc_pkg::SQ_W-1:0]           sq_z,
    input  wire logic [tdsc_pkg::THR_W-1:0]          tilt_limit,
    input  wire logic [tdsc_pkg::TAN2_W-1:0]         tan2_high,
    input  wire logic [tdsc_pkg::TAN2_W-1:0]         tan2_mid,
    input  wire logic [tdsc_pkg::TAN2_W-1:0]         tan2_low,
    output tdsc_pkg::tdsc_out_t                      result
);

    localparam int CW  = tdsc_pkg::FILT_W + 1;
    localparam int PAD = CW - tdsc_pkg::THR_W - tdsc_pkg::FRAC_BITS;
    localparam int FW  = tdsc_pkg::FILT_W;

    logic signed [CW-1:0]              thr_pos;
    logic signed [CW-1:0]              thr_neg;
    logic signed [CW-1:0]              fx_e;
    logic signed [CW-1:0]              fy_e;
    logic                              x_neg;
    logic                              x_pos;
    logic                              y_neg;
    logic                              y_pos;

    logic [2:0]                        dir_reg;
    logic [2:0]                        dir_next;
    logic [tdsc_pkg::SQ_W-1:0]         main_reg;
    logic [tdsc_pkg::SQ_W-1:0]         main_next;
    logic [tdsc_pkg::SQ_W-1:0]         other_reg;
    logic [tdsc_pkg::SQ_W-1:0]         other_next;

    logic [tdsc_pkg::TAN2_W-1:0]       bound [3];
    logic [tdsc_pkg::PROD_W-1:0]       plo_reg [3];
    logic [tdsc_pkg::PROD_W-1:0]       phi_reg [3];
    logic [tdsc_pkg::CMP_W-1:0]        lhs;
    logic [tdsc_pkg::CMP_W-1:0]        rhs [3];
    logic [2:0]                        steep;

    // strict threshold tests on the filtered x and y axes
    always_comb
    begin
        thr_pos = $signed({{PAD{1'b0}}, tilt_limit, {tdsc_pkg::FRAC_BITS{1'b0}}});
        thr_neg = -thr_pos;
        fx_e    = CW'(filt_x);
        fy_e    = CW'(filt_y);
        x_neg   = fx_e < thr_neg;
        x_pos   = fx_e > thr_pos;
        y_neg   = fy_e < thr_neg;
        y_pos   = fy_e > thr_pos;
    end

    // pick direction and the squared terms for the slope test, x first
    always_comb
    begin
        dir_next   = tdsc_pkg::DIR_NEUTRAL;
        main_next  = '0;
        other_next = '0;
        if (x_neg || x_pos)
        begin
            dir_next   = x_neg ? tdsc_pkg::DIR_FORWARD : tdsc_pkg::DIR_BACKWARD;
            main_next  = sq_x;
            other_next = sq_y + sq_z;
        end
        else if (y_neg || y_pos)
        begin
            dir_next   = y_neg ? tdsc_pkg::DIR_LEFT : tdsc_pkg::DIR_RIGHT;
            main_next  = sq_y;
            other_next = sq_x + sq_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sel_en)
        begin
            dir_reg   <= dir_next;
            main_reg  <= main_next;
            other_reg <= other_next;
        end
    end

    assign bound[0] = tan2_high;
    assign bound[1] = tan2_mid;
    assign bound[2] = tan2_low;

    // bound times other terms, split in two halves per bound
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= tdsc_pkg::PROD_W'(bound[j]) * tdsc_pkg::PROD_W'(other_reg[FW-1:0]);
                phi_reg[j] <= tdsc_pkg::PROD_W'(bound[j])
                              * tdsc_pkg::PROD_W'(other_reg[tdsc_pkg::SQ_W-1:FW]);
            end
        end
    end

    // recombine halves and compare against 256 * main
    always_comb
    begin
        lhs = tdsc_pkg::CMP_W'({main_reg, {tdsc_pkg::WEIGHT_SH{1'b0}}});
        for (int j = 0; j < 3; j++)
        begin
            rhs[j]   = tdsc_pkg::CMP_W'({phi_reg[j], {FW{1'b0}}})
                       + tdsc_pkg::CMP_W'(plo_reg[j]);
            steep[j] = lhs > rhs[j];
        end
    end

    // first passing bound wins: high, then mid, then low
    always_comb
    begin
        result.direction = dir_reg;
        if (dir_reg == tdsc_pkg::DIR_NEUTRAL)
        begin
            result.speed = tdsc_pkg::SPEED_NONE;
        end
        else if (steep[0])
        begin
            result.speed = tdsc_pkg::SPEED_4;
        end
        else if (steep[1])
        begin
            result.speed = tdsc_pkg::SPEED_3;
        end
        else if (steep[2])
        begin
            result.speed = tdsc_pkg::SPEED_2;
        end
        else
        begin
            result.speed = tdsc_pkg::SPEED_1;
        end
    end

endmodule

`default_nettype wire
